>>> design/power_sum_mod_prime_core_assert.svh
// Assertion macros for the power sum core.
// Used by power_sum_mod_prime_core; no other dependencies.
`ifndef POWER_SUM_MOD_PRIME_CORE_ASSERT_SVH
`define POWER_SUM_MOD_PRIME_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// checked only out of reset
`define PSM_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on every edge
`define PSM_ASSERT_ALL(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PSM_ASSERT_RST(lbl, prop, msg)
`define PSM_ASSERT_ALL(lbl, prop, msg)
`endif
`endif

>>> design/psm_pkg.sv
// Shared types and constants for the power sum core.
// No dependencies.
package psm_pkg;

  localparam int unsigned MAX_POWER_DEF = 16384;
  localparam int unsigned MOD_WIDTH_DEF = 32;
  localparam int unsigned CL_W          = 40;
  localparam int unsigned PWR_W         = 15;
  localparam int unsigned IN_W          = 32;
  localparam int unsigned OUT_W         = 32;
  // serial multiplier operand: wide enough for count_limit + 1
  localparam int unsigned BOP_W         = CL_W + 1;
  localparam int unsigned CNT_W         = 6;

  localparam logic [CL_W-1:0]  CL_RESET  = 40'd1000000000000;
  localparam logic [PWR_W-1:0] PWR_RESET = 15'd10000;

  typedef enum logic [0:0] {
    CFG_COUNT_LIMIT = 1'b0,
    CFG_POWER       = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    A_ONE, A_C, A_ACC, A_PW, A_POWR
  } a_sel_t;

  typedef enum logic [3:0] {
    B_N, B_N1, B_I, B_IJ, B_SJ, B_INV, B_BASE, B_POWR, B_EBASE
  } b_sel_t;

  typedef enum logic [2:0] {
    D_EBASE, D_POWR, D_SRES, D_BASE, D_PW, D_ACCSUB, D_C
  } dst_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_INV_BASE, ST_INV_SQ, ST_INV_MUL, ST_INV_WR,
    ST_S0, ST_S0_WR, ST_BASE, ST_PW, ST_RD, ST_MSUB, ST_MBIN,
    ST_MINV, ST_RD_FIN, ST_FIN, ST_S_WR, ST_DONE
  } state_t;

  typedef struct packed {
    logic   start;
    a_sel_t a_sel;
    b_sel_t b_sel;
    dst_t   dst;
    logic   load;
    logic   powr_init;
    logic   s_we;
    logic   s_re;
    logic   v_we;
    logic   v_re;
    logic   v_rd_i;
    logic   out_load;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic ebit;
    logic m_small;
  } sts_t;

endpackage

>>> design/psm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module psm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> design/psm_dp.sv
// Datapath: bit-serial modular multiplier, working registers, table RAMs.
// Depends on psm_pkg and psm_ram.
module psm_dp #(
  parameter int unsigned MAX_POWER = psm_pkg::MAX_POWER_DEF,
  parameter int unsigned MOD_WIDTH = psm_pkg::MOD_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  psm_pkg::cmd_t                   cmd,
  input  logic [$clog2(MAX_POWER+3)-1:0]  i_idx,
  input  logic [$clog2(MAX_POWER+3)-1:0]  j_idx,
  input  logic [$clog2(MOD_WIDTH)-1:0]    bit_idx,
  input  logic [psm_pkg::IN_W-1:0]        in_modulus,
  input  logic [psm_pkg::CL_W-1:0]        count_limit,
  output psm_pkg::sts_t                   sts,
  output logic [psm_pkg::OUT_W-1:0]       out_power_sum
);
  import psm_pkg::*;

  localparam int unsigned MW  = MOD_WIDTH;
  localparam int unsigned IW  = $clog2(MAX_POWER + 3);
  localparam int unsigned SAW = $clog2(MAX_POWER + 1);
  localparam int unsigned VAW = $clog2(MAX_POWER + 2);
  localparam int unsigned BW  = BOP_W;

  logic [MW-1:0]    m_r, exp_r;
  logic [MW-1:0]    a_r, r_r;
  logic [BW-1:0]    b_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  dst_t             dst_r;
  logic [MW-1:0]    ebase_r, powr_r, base_r, pw_r, acc_r, c_r, sres_r, out_r;
  logic [MW-1:0]    s_rdata, v_rdata;

  // operand selection at multiply start
  logic [MW-1:0]    a_val;
  logic [BW-1:0]    b_val;
  logic [CNT_W-1:0] b_steps;
  logic [IW-1:0]    ij_val;
  logic [MW-1:0]    mw_b;

  assign ij_val = i_idx + IW'(1) - j_idx;

  always_comb begin
    unique case (cmd.a_sel)
      A_ONE:   a_val = MW'(1);
      A_C:     a_val = c_r;
      A_ACC:   a_val = acc_r;
      A_PW:    a_val = pw_r;
      A_POWR:  a_val = powr_r;
      default: a_val = MW'(1);
    endcase
  end

  always_comb begin
    mw_b    = '0;
    b_val   = '0;
    b_steps = CNT_W'(MW);
    unique case (cmd.b_sel)
      B_N: begin
        b_val   = {count_limit, 1'b0};
        b_steps = CNT_W'(CL_W);
      end
      B_N1: begin
        b_val   = {1'b0, count_limit} + BW'(1);
        b_steps = CNT_W'(BW);
      end
      B_I: begin
        b_val   = {i_idx, {(BW-IW){1'b0}}};
        b_steps = CNT_W'(IW);
      end
      B_IJ: begin
        b_val   = {ij_val, {(BW-IW){1'b0}}};
        b_steps = CNT_W'(IW);
      end
      B_SJ:    mw_b = s_rdata;
      B_INV:   mw_b = v_rdata;
      B_BASE:  mw_b = base_r;
      B_POWR:  mw_b = powr_r;
      B_EBASE: mw_b = ebase_r;
      default: mw_b = '0;
    endcase
    if (cmd.b_sel != B_N && cmd.b_sel != B_N1 && cmd.b_sel != B_I &&
        cmd.b_sel != B_IJ) begin
      b_val = {mw_b, {(BW-MW){1'b0}}};
    end
  end

  // one step: r = 2r + bit*a, reduced below m
  logic [MW:0]   t2, u2;
  logic [MW-1:0] t, u;
  logic          done;

  always_comb begin
    t2 = {r_r, 1'b0};
    t  = (t2 >= {1'b0, m_r}) ? MW'(t2 - {1'b0, m_r}) : MW'(t2);
    u2 = {1'b0, t} + (b_r[BW-1] ? {1'b0, a_r} : {(MW+1){1'b0}});
    u  = (u2 >= {1'b0, m_r}) ? MW'(u2 - {1'b0, m_r}) : MW'(u2);
  end

  assign done = busy_r && (cnt_r == CNT_W'(1));

  // multiplier control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (cmd.start) begin
      busy_r <= 1'b1;
    end else if (done) begin
      busy_r <= 1'b0;
    end
  end

  // multiplier payload and working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      m_r    <= in_modulus[MW-1:0];
      exp_r  <= in_modulus[MW-1:0] - MW'(2);
      sres_r <= '0;
    end
    if (cmd.start) begin
      a_r   <= a_val;
      b_r   <= b_val;
      cnt_r <= b_steps;
      r_r   <= '0;
      dst_r <= cmd.dst;
    end else if (busy_r) begin
      r_r   <= u;
      b_r   <= {b_r[BW-2:0], 1'b0};
      cnt_r <= cnt_r - CNT_W'(1);
    end
    if (cmd.powr_init) begin
      powr_r <= MW'(1);
    end
    if (done) begin
      unique case (dst_r)
        D_EBASE: ebase_r <= u;
        D_POWR:  powr_r  <= u;
        D_SRES:  sres_r  <= u;
        D_BASE: begin
          base_r <= u;
          pw_r   <= u;
        end
        D_PW: begin
          pw_r  <= u;
          acc_r <= (u == '0) ? m_r - MW'(1) : u - MW'(1);
          c_r   <= MW'(1);
        end
        D_ACCSUB: acc_r <= (acc_r >= u) ? acc_r - u : acc_r - u + m_r;
        D_C:      c_r   <= u;
        default:  c_r   <= u;
      endcase
    end
    if (cmd.out_load) begin
      out_r <= sres_r;
    end
  end

  // partial sum and inverse tables
  logic [IW-1:0] v_raddr_w;
  assign v_raddr_w = cmd.v_rd_i ? i_idx + IW'(1) : j_idx + IW'(1);

  psm_ram #(.WIDTH(MW), .DEPTH(MAX_POWER + 1)) u_sums (
    .clk   (clk),
    .we    (cmd.s_we),
    .waddr (i_idx[SAW-1:0]),
    .wdata (sres_r),
    .re    (cmd.s_re),
    .raddr (j_idx[SAW-1:0]),
    .rdata (s_rdata)
  );

  psm_ram #(.WIDTH(MW), .DEPTH(MAX_POWER + 2)) u_invs (
    .clk   (clk),
    .we    (cmd.v_we),
    .waddr (i_idx[VAW-1:0]),
    .wdata (powr_r),
    .re    (cmd.v_re),
    .raddr (v_raddr_w[VAW-1:0]),
    .rdata (v_rdata)
  );

  assign sts.busy    = busy_r;
  assign sts.done    = done;
  assign sts.ebit    = exp_r[bit_idx];
  assign sts.m_small = (in_modulus[MW-1:0] < MW'(2));

  assign out_power_sum = OUT_W'(out_r);

endmodule

>>> design/psm_ctrl.sv
// Controller: sequences inverses, the partial sum recurrence and handshakes.
// Depends on psm_pkg.
module psm_ctrl #(
  parameter int unsigned MAX_POWER = psm_pkg::MAX_POWER_DEF,
  parameter int unsigned MOD_WIDTH = psm_pkg::MOD_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  output logic                            out_valid,
  input  logic                            out_stall,
  input  logic [psm_pkg::PWR_W-1:0]       power,
  input  psm_pkg::sts_t                   sts,
  output psm_pkg::cmd_t                   cmd,
  output logic [$clog2(MAX_POWER+3)-1:0]  i_idx,
  output logic [$clog2(MAX_POWER+3)-1:0]  j_idx,
  output logic [$clog2(MOD_WIDTH)-1:0]    bit_idx
);
  import psm_pkg::*;

  localparam int unsigned IW    = $clog2(MAX_POWER + 3);
  localparam int unsigned BIT_W = $clog2(MOD_WIDTH);

  state_t           state_r, state_nxt;
  logic [IW-1:0]    i_r, i_nxt, j_r, j_nxt, p_eff;
  logic [BIT_W-1:0] bit_r, bit_nxt;
  logic             out_valid_r, out_valid_nxt;

  // exponent saturates at the table size
  assign p_eff = (32'(power) > MAX_POWER) ? IW'(MAX_POWER) : IW'(power);

  // next state and loop counters
  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    bit_nxt   = bit_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          i_nxt     = IW'(1);
          state_nxt = sts.m_small ? ST_DONE : ST_INV_BASE;
        end
      end
      ST_INV_BASE: begin
        if (sts.done) begin
          bit_nxt   = BIT_W'(MOD_WIDTH - 1);
          state_nxt = ST_INV_SQ;
        end
      end
      ST_INV_SQ, ST_INV_MUL: begin
        if (sts.done) begin
          if (state_r == ST_INV_SQ && sts.ebit) begin
            state_nxt = ST_INV_MUL;
          end else if (bit_r == '0) begin
            state_nxt = ST_INV_WR;
          end else begin
            bit_nxt   = bit_r - BIT_W'(1);
            state_nxt = ST_INV_SQ;
          end
        end
      end
      ST_INV_WR: begin
        if (i_r == p_eff + IW'(1)) begin
          i_nxt     = '0;
          state_nxt = ST_S0;
        end else begin
          i_nxt     = i_r + IW'(1);
          state_nxt = ST_INV_BASE;
        end
      end
      ST_S0: begin
        if (sts.done) state_nxt = ST_S0_WR;
      end
      ST_S0_WR: begin
        i_nxt     = IW'(1);
        state_nxt = ST_BASE;
      end
      ST_BASE: begin
        if (sts.done) state_nxt = (p_eff == '0) ? ST_DONE : ST_PW;
      end
      ST_PW: begin
        if (sts.done) begin
          j_nxt     = '0;
          state_nxt = ST_RD;
        end
      end
      ST_RD:   state_nxt = ST_MSUB;
      ST_MSUB: begin
        if (sts.done) state_nxt = ST_MBIN;
      end
      ST_MBIN: begin
        if (sts.done) state_nxt = ST_MINV;
      end
      ST_MINV: begin
        if (sts.done) begin
          if (j_r == i_r - IW'(1)) begin
            state_nxt = ST_RD_FIN;
          end else begin
            j_nxt     = j_r + IW'(1);
            state_nxt = ST_RD;
          end
        end
      end
      ST_RD_FIN: state_nxt = ST_FIN;
      ST_FIN: begin
        if (sts.done) state_nxt = ST_S_WR;
      end
      ST_S_WR: begin
        if (i_r == p_eff) begin
          state_nxt = ST_DONE;
        end else begin
          i_nxt     = i_r + IW'(1);
          state_nxt = ST_PW;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // commands to the datapath
  always_comb begin
    cmd       = '0;
    cmd.a_sel = A_ONE;
    cmd.b_sel = B_N;
    cmd.dst   = D_SRES;
    unique case (state_r)
      ST_IDLE:     cmd.load = in_valid;
      ST_INV_BASE: begin
        cmd.start     = !sts.busy;
        cmd.powr_init = !sts.busy;
        cmd.b_sel     = B_I;
        cmd.dst       = D_EBASE;
      end
      ST_INV_SQ: begin
        cmd.start = !sts.busy;
        cmd.a_sel = A_POWR;
        cmd.b_sel = B_POWR;
        cmd.dst   = D_POWR;
      end
      ST_INV_MUL: begin
        cmd.start = !sts.busy;
        cmd.a_sel = A_POWR;
        cmd.b_sel = B_EBASE;
        cmd.dst   = D_POWR;
      end
      ST_INV_WR:   cmd.v_we = 1'b1;
      ST_S0:       cmd.start = !sts.busy;
      ST_S0_WR:    cmd.s_we = 1'b1;
      ST_BASE: begin
        cmd.start = !sts.busy;
        cmd.b_sel = B_N1;
        cmd.dst   = D_BASE;
      end
      ST_PW: begin
        cmd.start = !sts.busy;
        cmd.a_sel = A_PW;
        cmd.b_sel = B_BASE;
        cmd.dst   = D_PW;
      end
      ST_RD: begin
        cmd.s_re = 1'b1;
        cmd.v_re = 1'b1;
      end
      ST_MSUB: begin
        cmd.start = !sts.busy;
        cmd.a_sel = A_C;
        cmd.b_sel = B_SJ;
        cmd.dst   = D_ACCSUB;
      end
      ST_MBIN: begin
        cmd.start = !sts.busy;
        cmd.a_sel = A_C;
        cmd.b_sel = B_IJ;
        cmd.dst   = D_C;
      end
      ST_MINV: begin
        cmd.start = !sts.busy;
        cmd.a_sel = A_C;
        cmd.b_sel = B_INV;
        cmd.dst   = D_C;
      end
      ST_RD_FIN: begin
        cmd.v_re   = 1'b1;
        cmd.v_rd_i = 1'b1;
      end
      ST_FIN: begin
        cmd.start = !sts.busy;
        cmd.a_sel = A_ACC;
        cmd.b_sel = B_INV;
        cmd.dst   = D_SRES;
      end
      ST_S_WR:     cmd.s_we = 1'b1;
      ST_DONE:     cmd.out_load = !out_valid_r || !out_stall;
      default:     cmd.load = 1'b0;
    endcase
  end

  // result register handshake
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (cmd.out_load)              out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
      bit_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      bit_r       <= bit_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign i_idx     = i_r;
  assign j_idx     = j_r;
  assign bit_idx   = bit_r;

endmodule

>>> design/power_sum_mod_prime_core.sv
// Power sum modulo a prime: each request carries a modulus m and returns
// sum of k^P for k=1..N mod m, with N (count_limit) and P (power) set over
// the cfg port while idle. One request is worked at a time; a finished result
// waits in the output register while the next request is taken. All
// arithmetic runs through one bit-serial modular multiplier (one operand bit
// per cycle), so the inner loop of the binomial recurrence dominates the run
// time, ahead of the Fermat inverses (powers to m-2), whose work grows with
// the number of set bits in m-2. A modulus below two returns zero. Power
// above MAX_POWER is treated as MAX_POWER.
module power_sum_mod_prime_core #(
  parameter int unsigned MAX_POWER = psm_pkg::MAX_POWER_DEF,
  parameter int unsigned MOD_WIDTH = psm_pkg::MOD_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [psm_pkg::IN_W-1:0]   in_modulus,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [psm_pkg::OUT_W-1:0]  out_power_sum,
  input  logic                       cfg_we,
  input  logic [0:0]                 cfg_index,
  input  logic [psm_pkg::CL_W-1:0]   cfg_wdata
);
  import psm_pkg::*;

  localparam int unsigned IW    = $clog2(MAX_POWER + 3);
  localparam int unsigned BIT_W = $clog2(MOD_WIDTH);

  logic [CL_W-1:0]  count_limit_r;
  logic [PWR_W-1:0] power_r;
  cmd_t             cmd;
  sts_t             sts;
  logic [IW-1:0]    i_idx, j_idx;
  logic [BIT_W-1:0] bit_idx;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_limit_r <= CL_RESET;
      power_r       <= PWR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_COUNT_LIMIT: count_limit_r <= cfg_wdata;
        CFG_POWER:       power_r       <= cfg_wdata[PWR_W-1:0];
        default:         power_r       <= power_r;
      endcase
    end
  end

  psm_ctrl #(.MAX_POWER(MAX_POWER), .MOD_WIDTH(MOD_WIDTH)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .power     (power_r),
    .sts       (sts),
    .cmd       (cmd),
    .i_idx     (i_idx),
    .j_idx     (j_idx),
    .bit_idx   (bit_idx)
  );

  psm_dp #(.MAX_POWER(MAX_POWER), .MOD_WIDTH(MOD_WIDTH)) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .i_idx         (i_idx),
    .j_idx         (j_idx),
    .bit_idx       (bit_idx),
    .in_modulus    (in_modulus),
    .count_limit   (count_limit_r),
    .sts           (sts),
    .out_power_sum (out_power_sum)
  );

`include "power_sum_mod_prime_core_assert.svh"

  // a product is never started on top of a running one
  `PSM_ASSERT_RST(a_start_idle, cmd.start |-> !sts.busy, "multiply started while busy")
  // table writes only happen with the multiplier quiet
  `PSM_ASSERT_RST(a_wr_idle, (cmd.s_we || cmd.v_we) |-> !sts.busy, "table write while busy")
  // a loaded result is presented on the next cycle
  `PSM_ASSERT_ALL(a_out_load, rst_n && cmd.out_load |=> out_valid, "result not presented")

endmodule

>>> sim/power_sum_mod_prime_core_checker.sv
// Checker for power_sum_mod_prime_core: watches the request, result and cfg
// ports, predicts each power sum and compares it. Depends on psm_pkg.
module power_sum_mod_prime_core_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic [psm_pkg::IN_W-1:0]  in_modulus,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic [psm_pkg::OUT_W-1:0] out_power_sum,
  input  logic                      cfg_we,
  input  logic [0:0]                cfg_index,
  input  logic [psm_pkg::CL_W-1:0]  cfg_wdata,
  output int                        fail_count,
  output int                        pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import psm_pkg::*;

  logic [CL_W-1:0]  count_limit;
  logic [PWR_W-1:0] power;
  logic [31:0]      sums [0:MAX_POWER_DEF];
  logic [31:0]      fermat_inv [0:MAX_POWER_DEF+1];
  logic [OUT_W-1:0] sum_queue [$];

  function automatic longint unsigned mod_mul(longint unsigned a, longint unsigned b,
                                              longint unsigned m);
    return (a * b) % m;
  endfunction

  function automatic longint unsigned mod_pow(longint unsigned b, longint unsigned e,
                                              longint unsigned m);
    longint unsigned r;
    r = 1;
    b = b % m;
    while (e > 0) begin
      if (e[0]) r = mod_mul(r, b, m);
      b = mod_mul(b, b, m);
      e = e >> 1;
    end
    return r;
  endfunction

  // Binomial recurrence over S_0..S_P, returns S_P mod m
  function automatic logic [31:0] power_sum_of(logic [31:0] modulus);
    longint unsigned m, p, base, pw, acc, c;
    m = 64'(modulus);
    p = 64'(power);
    if (p > MAX_POWER_DEF) p = MAX_POWER_DEF;
    if (m < 2) return '0;
    for (longint unsigned i = 1; i <= p + 1; i++)
      fermat_inv[i] = 32'(mod_pow(i, m - 2, m));
    base = (64'(count_limit) + 1) % m;
    sums[0] = 32'(64'(count_limit) % m);
    pw = base;
    for (longint unsigned i = 1; i <= p; i++) begin
      c = 1;
      pw = mod_mul(pw, base, m);
      acc = (pw + m - 1) % m;
      for (longint unsigned j = 0; j < i; j++) begin
        acc = (acc + m - mod_mul(c, 64'(sums[j]), m)) % m;
        c = mod_mul(c, (i + 1 - j) % m, m);
        c = mod_mul(c, 64'(fermat_inv[j + 1]), m);
      end
      sums[i] = 32'(mod_mul(acc, 64'(fermat_inv[i + 1]), m));
    end
    return sums[p];
  endfunction

  task automatic report(string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
    count_limit = CL_RESET;
    power = PWR_RESET;
  end

  // Track config, queue predictions, compare results
  always @(posedge clk) begin
    logic [OUT_W-1:0] want;
    if (!rst_n) begin
      count_limit = CL_RESET;
      power = PWR_RESET;
      sum_queue.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (sum_queue.size() == 0) begin
          report($sformatf("result %0d with no request outstanding", out_power_sum));
        end else begin
          want = sum_queue.pop_front();
          if (out_power_sum !== want)
            report($sformatf("power_sum got %0d want %0d", out_power_sum, want));
        end
      end
      if (in_valid && !in_stall) sum_queue = {sum_queue, power_sum_of(in_modulus)};
      if (cfg_we) begin
        if (cfg_index == CFG_COUNT_LIMIT) count_limit = cfg_wdata;
        else power = cfg_wdata[PWR_W-1:0];
      end
    end
    pending = sum_queue.size();
  end

endmodule

>>> sim/power_sum_mod_prime_core_test.sv
// Top of the power sum testbench: clock, reset, request and cfg stimulus,
// result-side stalls and the verdict. Depends on psm_pkg and the checker.
module power_sum_mod_prime_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import psm_pkg::*;

  localparam logic [CL_W-1:0] CL_MAX = 40'hFF_FFFF_FFFF;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [IN_W-1:0]   in_modulus = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [OUT_W-1:0]  out_power_sum;
  logic              cfg_we = 1'b0;
  logic [0:0]        cfg_index = CFG_COUNT_LIMIT;
  logic [CL_W-1:0]   cfg_wdata = '0;
  int                fail_count;
  int                pending;
  bit                noisy = 1'b1;
  bit                hold_req = 1'b0;

  always #2 clk = ~clk;

  power_sum_mod_prime_core uut (
    .clk, .rst_n, .in_valid, .in_stall, .in_modulus, .out_valid, .out_stall,
    .out_power_sum, .cfg_we, .cfg_index, .cfg_wdata
  );

  power_sum_mod_prime_core_checker checker_i (
    .clk, .rst_n, .in_valid, .in_stall, .in_modulus, .out_valid, .out_stall,
    .out_power_sum, .cfg_we, .cfg_index, .cfg_wdata, .fail_count, .pending
  );

  // Result side: random stall bursts plus one long hold-off
  initial begin
    int burst;
    bit hold_done;
    burst = 0;
    hold_done = 0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        repeat (30000) @(negedge clk);
        hold_done = 1;
      end
      if (burst > 0) burst--;
      else if (noisy && $urandom_range(0, 7) == 0) burst = $urandom_range(1, 6);
      out_stall <= (burst > 0);
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  // with in_valid still high.
  task automatic send_request(logic [IN_W-1:0] modulus);
    int gap;
    gap = (noisy && $urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_modulus <= modulus;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Drop valid and wait for every outstanding result
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_cfg(cfg_idx_t idx, logic [CL_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [IN_W-1:0] rand_modulus();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 1);
      1, 2, 3: return $urandom_range(2, 100);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [CL_W-1:0] limit;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset config: power 10000 is only affordable with trivial moduli
    send_request(32'd0);
    send_request(32'd1);
    drain();
    // Saturating power, largest count
    write_cfg(CFG_POWER, 40'h7FFF);
    write_cfg(CFG_COUNT_LIMIT, CL_MAX);
    send_request(32'd1);
    send_request(32'd0);
    drain();
    // Power zero returns N mod m; count zero
    write_cfg(CFG_POWER, 40'd0);
    write_cfg(CFG_COUNT_LIMIT, '0);
    send_request(32'd2);
    send_request(32'd3);
    send_request(32'hFFFF_FFFF);
    drain();
    write_cfg(CFG_COUNT_LIMIT, CL_MAX);
    send_request(32'hFFFF_FFFB);
    send_request(32'd7);
    drain();
    // Non-prime and too-small moduli still run the full recurrence
    write_cfg(CFG_POWER, 40'd1);
    send_request(32'd5);
    send_request(32'hFFFF_FFFB);
    send_request(32'd4);
    send_request(32'd2);
    drain();
    write_cfg(CFG_POWER, 40'd3);
    write_cfg(CFG_COUNT_LIMIT, 40'd1000000);
    send_request(32'd13);
    send_request(32'd3);
    send_request(32'h8000_0001);
    drain();

    // Long result hold-off so the core backs up and stalls its input
    write_cfg(CFG_POWER, 40'd1);
    hold_req = 1'b1;
    repeat (5) send_request(rand_modulus());
    drain();

    // Random phases; the last one runs without idling
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 7) noisy = 1'b0;
      limit = ($urandom_range(0, 2) == 0) ? CL_W'($urandom_range(0, 1000))
                                          : CL_W'({$urandom, $urandom});
      write_cfg(CFG_COUNT_LIMIT, limit);
      write_cfg(CFG_POWER,
                CL_W'(($urandom_range(0, 5) == 0) ? 5 : $urandom_range(0, 3)));
      repeat (11) send_request(rand_modulus());
      drain();
    end

    repeat (50) @(negedge clk);
    if (fail_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #40_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

>>> sim.f
+incdir+design
design/psm_pkg.sv
design/psm_ram.sv
design/psm_dp.sv
design/psm_ctrl.sv
design/power_sum_mod_prime_core.sv
sim/power_sum_mod_prime_core_checker.sv
sim/power_sum_mod_prime_core_test.sv
